// ===== sv/bbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Bang-bang positioner package
// Shared types, register indexes and constants for the positioner block.
// ----------------------------------------------------------------------------
`default_nettype none

package bbp_pkg;

    localparam int DEFAULT_POSITION_BITS = 10;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RUN_SPEED      = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CREEP_SPEED    = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HYSTERESIS     = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BRAKE_DISTANCE = 8'd3;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [7:0] IDLE_LEVEL = 8'hFF;

    typedef struct packed {
        logic [7:0] run_speed;
        logic [7:0] creep_speed;
        logic [4:0] hysteresis;
        logic [5:0] brake_distance;
    } cfg_t;

    typedef struct packed {
        logic       relay_one;
        logic       relay_two;
        logic [7:0] motor_level;
        logic       power_on;
        logic       busy_res;
        logic       arrived;
        logic       start_ignored;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/bbp_core.sv =====
// ----------------------------------------------------------------------------
// Bang-bang positioner core
// Move state and the single-pass decision logic for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module bbp_core #(
    parameter int POSITION_BITS = bbp_pkg::DEFAULT_POSITION_BITS
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      en,
    input  wire                      kind,
    input  wire  [POSITION_BITS-1:0] demand_position,
    input  wire  [POSITION_BITS-1:0] position,
    input  wire  bbp_pkg::cfg_t      cfg,
    output bbp_pkg::result_t         result
);
    import bbp_pkg::*;

    logic                     moving_reg, moving_next;
    logic                     dir_up_reg, dir_up_next;
    logic                     braking_reg, braking_next;
    logic                     held_reg, held_next;
    logic [POSITION_BITS-1:0] target_reg, target_next;

    logic [POSITION_BITS-1:0] span;
    logic [POSITION_BITS:0]   pos_ext, tgt_ext, bd_ext;
    logic                     start_ok, brake_hit, done;

    always_comb begin
        span = (demand_position >= position) ? demand_position - position
                                             : position - demand_position;
        start_ok = (span >= {{(POSITION_BITS-5){1'b0}}, cfg.hysteresis});
        pos_ext = {1'b0, position};
        tgt_ext = {1'b0, target_reg};
        bd_ext  = (POSITION_BITS+1)'(cfg.brake_distance);
        if (dir_up_reg) begin
            brake_hit = (pos_ext + bd_ext) >= tgt_ext;
            done      = position >= target_reg;
        end else begin
            brake_hit = pos_ext <= (tgt_ext + bd_ext);
            done      = position <= target_reg;
        end
    end

    always_comb begin
        moving_next  = moving_reg;
        dir_up_next  = dir_up_reg;
        braking_next = braking_reg;
        held_next    = held_reg;
        target_next  = target_reg;
        if (kind == KIND_START) begin
            if (!moving_reg && start_ok) begin
                moving_next  = 1'b1;
                braking_next = 1'b0;
                target_next  = demand_position;
                dir_up_next  = demand_position > position;
                held_next    = demand_position == position;
            end
        end else if (moving_reg) begin
            if (brake_hit) begin
                braking_next = 1'b1;
            end
            if (done) begin
                moving_next  = 1'b0;
                braking_next = 1'b0;
                held_next    = 1'b0;
            end
        end
    end

    always_comb begin
        result = '0;
        if (moving_next) begin
            result.relay_one   = held_next | dir_up_next;
            result.relay_two   = held_next | !dir_up_next;
            result.motor_level = braking_next ? cfg.creep_speed : cfg.run_speed;
            result.power_on    = 1'b1;
            result.busy_res    = 1'b1;
        end else begin
            result.relay_one   = 1'b1;
            result.relay_two   = 1'b1;
            result.motor_level = IDLE_LEVEL;
        end
        result.arrived       = (kind == KIND_SAMPLE) && moving_reg && done;
        result.start_ignored = (kind == KIND_START) && moving_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            moving_reg  <= 1'b0;
            dir_up_reg  <= 1'b0;
            braking_reg <= 1'b0;
            held_reg    <= 1'b0;
            target_reg  <= '0;
        end else if (en) begin
            moving_reg  <= moving_next;
            dir_up_reg  <= dir_up_next;
            braking_reg <= braking_next;
            held_reg    <= held_next;
            target_reg  <= target_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !moving_reg |-> !braking_reg && !held_reg)
        else $error("Brake or relay hold latched outside a move.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        en && moving_reg && kind == KIND_START |=> $stable(target_reg) && moving_reg)
        else $error("Ignored start word changed the running move.");

endmodule

`default_nettype wire

// ===== sv/bang_bang_positioner_with_brake_top.sv =====
// ----------------------------------------------------------------------------
// Bang-bang positioner with brake
// Top level: configuration registers, move core and a two-word result buffer.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while s_ready is high and returns
// exactly one result word for each, held in the output register (or the skid
// register while m_ready stalls); the decision is a few comparisons against the
// registered move state, done combinationally. The result side holds two words
// (an output register and a skid register), so s_ready drops only when both are
// occupied by a stalled m_ready. Configuration writes are always accepted and take effect from the next word on.
`default_nettype none

module bang_bang_positioner_with_brake_top #(
    parameter int POSITION_BITS = bbp_pkg::DEFAULT_POSITION_BITS
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire                                s_kind,
    input  wire  [POSITION_BITS-1:0]           s_demand_position,
    input  wire  [POSITION_BITS-1:0]           s_position,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic                               m_relay_one,
    output logic                               m_relay_two,
    output logic [7:0]                         m_motor_level,
    output logic                               m_power_on,
    output logic                               m_busy_res,
    output logic                               m_arrived,
    output logic                               m_start_ignored,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [bbp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire  [bbp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import bbp_pkg::*;

    cfg_t    cfg_reg;
    result_t core_result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    s_accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign s_accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_RUN_SPEED:      cfg_reg.run_speed      <= cfg_data;
                REG_CREEP_SPEED:    cfg_reg.creep_speed    <= cfg_data;
                REG_HYSTERESIS:     cfg_reg.hysteresis     <= cfg_data[4:0];
                REG_BRAKE_DISTANCE: cfg_reg.brake_distance <= cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    bbp_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (s_accept),
        .kind           (s_kind),
        .demand_position(s_demand_position),
        .position       (s_position),
        .cfg            (cfg_reg),
        .result         (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else if (s_accept) begin
                out_reg       <= core_result;
                out_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (s_accept) begin
            skid_reg       <= core_result;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_relay_one     = out_reg.relay_one;
    assign m_relay_two     = out_reg.relay_two;
    assign m_motor_level   = out_reg.motor_level;
    assign m_power_on      = out_reg.power_on;
    assign m_busy_res      = out_reg.busy_res;
    assign m_arrived       = out_reg.arrived;
    assign m_start_ignored = out_reg.start_ignored;

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds a word while the output register is empty.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_reg))
        else $error("Stalled result word changed or vanished.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.arrived && out_reg.busy_res)
                          && (out_reg.power_on == out_reg.busy_res))
        else $error("Result word reports an inconsistent move status.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && skid_valid_reg |-> 1'b0)
        else $error("Word accepted with both result registers full.");

endmodule

`default_nettype wire

// ===== verif/bang_bang_positioner_with_brake_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bang-bang positioner with brake: testbench
// Feeds start and sample words through the valid/ready input channel, writes
// the four drive registers between phases, and checks every result word
// against a cycle-free model of the move state (direction, brake latch,
// target). Directed moves cover the edge cases first. After them come random
// phases of well-formed moves mixed with noise. Sender gaps and receiver
// stalls vary per phase, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------

module testbench;
    import bbp_pkg::*;

    localparam int POS_BITS    = DEFAULT_POSITION_BITS;
    localparam int POS_MAX     = (1 << POS_BITS) - 1;
    localparam int HOLD_CYCLES = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_MAX  = 10;
    localparam result_t IDLE_RESULT = {1'b1, 1'b1, IDLE_LEVEL, 4'b0000};

    typedef struct packed {
        logic                kind;
        logic [POS_BITS-1:0] demand;
        logic [POS_BITS-1:0] position;
    } pos_word_t;

    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_kind = KIND_START;
    logic [POS_BITS-1:0]       s_demand_position = '0;
    logic [POS_BITS-1:0]       s_position = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_relay_one;
    logic                      m_relay_two;
    logic [7:0]                m_motor_level;
    logic                      m_power_on;
    logic                      m_busy_res;
    logic                      m_arrived;
    logic                      m_start_ignored;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    bang_bang_positioner_with_brake_top #(
        .POSITION_BITS(POS_BITS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_demand_position(s_demand_position),
        .s_position(s_position),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_relay_one(m_relay_one),
        .m_relay_two(m_relay_two),
        .m_motor_level(m_motor_level),
        .m_power_on(m_power_on),
        .m_busy_res(m_busy_res),
        .m_arrived(m_arrived),
        .m_start_ignored(m_start_ignored),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Model of the move state and the drive registers.
    cfg_t                model_cfg = '0;
    logic                moving = 1'b0;
    logic                dir_up = 1'b0;
    logic                braking = 1'b0;
    logic                relays_held = 1'b0;
    logic [POS_BITS-1:0] target_pos = '0;

    pos_word_t word_q[$];
    result_t   expected_q[$];
    int        words_loaded = 0;
    int        err_cnt = 0;
    int        idle_cycles = 0;

    pos_word_t cur_word;
    int        burst_left = 0;
    int        gap_left = 0;
    bit        send_gaps = 1'b0;

    rx_mode_t  rx_mode = RX_FREE;
    bit        hold_req = 1'b0;
    bit        hold_done = 1'b0;
    int        hold_cnt = 0;
    int        rx_tick = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic result_t moving_result();
        result_t r;
        r.relay_one     = relays_held || dir_up;
        r.relay_two     = relays_held || !dir_up;
        r.motor_level   = braking ? model_cfg.creep_speed : model_cfg.run_speed;
        r.power_on      = 1'b1;
        r.busy_res      = 1'b1;
        r.arrived       = 1'b0;
        r.start_ignored = 1'b0;
        return r;
    endfunction

    function automatic result_t predict_word(input pos_word_t w);
        result_t r;
        int      span;
        int      goal;
        int      zone;
        int      p;
        logic    reached;
        p    = int'(w.position);
        span = int'(w.demand) - p;
        if (span < 0) begin
            span = -span;
        end
        if (w.kind == KIND_START) begin
            if (moving) begin
                r = moving_result();
                r.start_ignored = 1'b1;
            end else if (span >= int'(model_cfg.hysteresis)) begin
                moving      = 1'b1;
                braking     = 1'b0;
                target_pos  = w.demand;
                dir_up      = w.demand > w.position;
                relays_held = w.demand == w.position;
                r = moving_result();
            end else begin
                r = IDLE_RESULT;
            end
        end else if (!moving) begin
            r = IDLE_RESULT;
        end else begin
            goal = int'(target_pos);
            zone = int'(model_cfg.brake_distance);
            if (dir_up) begin
                if (p >= goal - zone) begin
                    braking = 1'b1;
                end
                reached = p >= goal;
            end else begin
                if (p <= goal + zone) begin
                    braking = 1'b1;
                end
                reached = p <= goal;
            end
            if (reached) begin
                moving      = 1'b0;
                braking     = 1'b0;
                relays_held = 1'b0;
                r = IDLE_RESULT;
                r.arrived = 1'b1;
            end else begin
                r = moving_result();
            end
        end
        return r;
    endfunction

    // Sender: bursts of random length, separated by random gaps when send_gaps is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
            moving      = 1'b0;
            dir_up      = 1'b0;
            braking     = 1'b0;
            relays_held = 1'b0;
            target_pos  = '0;
        end else begin
            if (s_valid && s_ready) begin
                expected_q.push_back(predict_word(cur_word));
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (word_q.size() != 0) begin
                    cur_word = word_q.pop_front();
                    s_valid           <= 1'b1;
                    s_kind            <= cur_word.kind;
                    s_demand_position <= cur_word.demand;
                    s_position        <= cur_word.position;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        if (send_gaps && $urandom_range(0, 2) != 0) begin
                            gap_left <= $urandom_range(1, 6);
                        end
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern per phase, plus a single long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            rx_tick   <= 0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1;
            if (hold_req && !hold_done) begin
                m_ready  <= 1'b0;
                hold_cnt <= hold_cnt + 1;
                if (hold_cnt == HOLD_CYCLES) begin
                    hold_done <= 1'b1;
                end
            end else begin
                case (rx_mode)
                    RX_FREE: begin
                        m_ready <= 1'b1;
                    end
                    RX_RANDOM: begin
                        m_ready <= $urandom_range(0, 3) != 0;
                    end
                    default: begin
                        m_ready <= (rx_tick % 11) > 3;
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_relay_one, m_relay_two, m_motor_level, m_power_on,
                   m_busy_res, m_arrived, m_start_ignored};
            if (expected_q.size() == 0) begin
                if (err_cnt < REPORT_MAX) begin
                    $display("result word with none expected: %h", got);
                end
                err_cnt++;
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    if (err_cnt < REPORT_MAX) begin
                        $display({"mismatch: expected r1=%b r2=%b level=%0d power=%b busy=%b ",
                                  "arrived=%b ignored=%b, got r1=%b r2=%b level=%0d power=%b ",
                                  "busy=%b arrived=%b ignored=%b"},
                                 want.relay_one, want.relay_two, want.motor_level,
                                 want.power_on, want.busy_res, want.arrived,
                                 want.start_ignored, got.relay_one, got.relay_two,
                                 got.motor_level, got.power_on, got.busy_res,
                                 got.arrived, got.start_ignored);
                    end
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int clamp_pos(input int p);
        if (p < 0) begin
            return 0;
        end
        if (p > POS_MAX) begin
            return POS_MAX;
        end
        return p;
    endfunction

    function automatic void push_word(input logic kind, input int demand, input int pos);
        pos_word_t w;
        w.kind     = kind;
        w.demand   = POS_BITS'(demand);
        w.position = POS_BITS'(pos);
        word_q.push_back(w);
        words_loaded++;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            REG_RUN_SPEED: begin
                model_cfg.run_speed = val;
            end
            REG_CREEP_SPEED: begin
                model_cfg.creep_speed = val;
            end
            REG_HYSTERESIS: begin
                model_cfg.hysteresis = val[4:0];
            end
            REG_BRAKE_DISTANCE: begin
                model_cfg.brake_distance = val[5:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic wait_drained();
        while (word_q.size() != 0 || s_valid || expected_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // A start followed by samples stepping toward the demand, sometimes
    // overshooting, sometimes abandoned, with stray starts during the move.
    task automatic add_move();
        int goal;
        int origin;
        int steps;
        int p;
        goal = $urandom_range(0, POS_MAX);
        case ($urandom_range(0, 7))
            0: begin
                origin = goal;
            end
            1: begin
                origin = clamp_pos(goal + int'($urandom_range(0, 64)) - 32);
            end
            default: begin
                origin = $urandom_range(0, POS_MAX);
            end
        endcase
        push_word(KIND_START, goal, origin);
        steps = $urandom_range(1, 10);
        for (int k = 1; k <= steps; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                break;
            end
            p = origin + (goal - origin) * k / steps;
            if (k == steps) begin
                p = (goal > origin) ? p + int'($urandom_range(0, 8))
                                    : p - int'($urandom_range(0, 8));
            end
            p = clamp_pos(p);
            if ($urandom_range(0, 9) == 0) begin
                push_word(KIND_START, $urandom_range(0, POS_MAX), p);
            end
            push_word(KIND_SAMPLE, $urandom_range(0, POS_MAX), p);
        end
    endtask

    task automatic fill_random(input int count);
        int stop_at;
        stop_at = words_loaded + count;
        while (words_loaded < stop_at) begin
            if ($urandom_range(0, 7) == 0) begin
                push_word(1'($urandom_range(0, 1)), $urandom_range(0, POS_MAX),
                          $urandom_range(0, POS_MAX));
            end else begin
                add_move();
            end
        end
    endtask

    initial begin
        bit       gaps_on;
        rx_mode_t mode_sel;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // All registers at reset: a move with demand equal to position holds
        // both relays high, and a start during the move is ignored.
        push_word(KIND_SAMPLE, 0, 0);
        push_word(KIND_START, 0, 0);
        push_word(KIND_START, POS_MAX, POS_MAX);
        push_word(KIND_SAMPLE, POS_MAX, POS_MAX);
        push_word(KIND_SAMPLE, 0, 0);
        wait_drained();

        write_reg(REG_RUN_SPEED, 8'd200);
        write_reg(REG_CREEP_SPEED, 8'd50);
        write_reg(REG_HYSTERESIS, 8'd25);
        write_reg(REG_BRAKE_DISTANCE, 8'd50);
        rx_mode <= RX_RANDOM;
        send_gaps <= 1'b1;
        push_word(KIND_START, 10, 0);
        push_word(KIND_START, POS_MAX, 0);
        push_word(KIND_SAMPLE, 0, 500);
        push_word(KIND_SAMPLE, 0, POS_MAX - 50);
        push_word(KIND_SAMPLE, 0, 100);
        push_word(KIND_SAMPLE, 0, POS_MAX);
        push_word(KIND_START, 20, POS_MAX);
        push_word(KIND_SAMPLE, 0, 70);
        push_word(KIND_SAMPLE, 0, 0);
        // Upward move whose target lies inside the brake distance from zero,
        // at a distance exactly equal to the hysteresis.
        push_word(KIND_START, 30, 5);
        push_word(KIND_SAMPLE, 0, 5);
        push_word(KIND_SAMPLE, 0, 30);
        wait_drained();

        // Out-of-range register values are kept at their width.
        write_reg(REG_RUN_SPEED, 8'hFF);
        write_reg(REG_CREEP_SPEED, 8'h00);
        write_reg(REG_HYSTERESIS, 8'hFF);
        write_reg(REG_BRAKE_DISTANCE, 8'hFF);
        write_reg(8'hFF, 8'hAA);
        write_reg(8'd4, 8'h55);
        rx_mode <= RX_PATTERN;
        push_word(KIND_START, POS_MAX, POS_MAX - 31);
        push_word(KIND_SAMPLE, 0, POS_MAX - 23);
        push_word(KIND_SAMPLE, POS_MAX, POS_MAX);
        push_word(KIND_START, 0, 30);
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_RUN_SPEED, 8'($urandom_range(0, 255)));
            write_reg(REG_CREEP_SPEED, 8'($urandom_range(0, 255)));
            write_reg(REG_HYSTERESIS,
                      8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 25)));
            write_reg(REG_BRAKE_DISTANCE,
                      8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 50)));
            mode_sel = rx_mode_t'($urandom_range(0, 2));
            gaps_on  = $urandom_range(0, 2) != 0;
            if (ph == 2) begin
                hold_req <= 1'b1;
                mode_sel = RX_FREE;
                gaps_on  = 1'b0;
            end
            rx_mode   <= mode_sel;
            send_gaps <= gaps_on;
            fill_random(95);
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (err_cnt == 0 && expected_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== bang_bang_positioner_with_brake_top.f =====
sv/bbp_pkg.sv
sv/bbp_core.sv
sv/bang_bang_positioner_with_brake_top.sv
verif/bang_bang_positioner_with_brake_tb.sv
